### rtl/wcma_pkg.sv
package wcma_pkg;

  // Array geometry
  localparam int NUM_CLUSTERS  = 8;
  localparam int NUM_VARIABLES = 8;
  localparam int ENTRY_COUNT   = NUM_CLUSTERS * NUM_VARIABLES;
  localparam int ADDR_W        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  // Field and datapath widths
  localparam int WGT_W  = 16;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 32;
  localparam int ACC_W  = 64;
  localparam int PROD_W = WGT_W + 1 + VAL_W;
  localparam int STEP_W = $clog2(ACC_W);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic REQ_ACC  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Saturation limits of the mean
  localparam logic [VAL_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] MEAN_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_ACC,   // add weight * value into the entry
    CMD_RD,    // divide the entry by the weight sum and clear it
    CMD_ZERO,  // zero weight sum: clear the entry, mean is zero
    CMD_NULL   // pair out of range: mean is zero, no state change
  } cmd_kind_e;

  typedef struct packed {
    logic                    req_type;
    logic [2:0]              cluster_index;
    logic [2:0]              variable_index;
    logic [WGT_W-1:0]        weight;
    logic signed [VAL_W-1:0] sample_value;
    logic [SUM_W-1:0]        weight_sum;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] mean_value;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [ADDR_W-1:0]       addr;
    logic [WGT_W-1:0]        weight;
    logic signed [VAL_W-1:0] sample_value;
    logic [SUM_W-1:0]        weight_sum;
  } cmd_t;

endpackage

### rtl/wcma_div.sv
module wcma_div import wcma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] dividend_i,
  input  logic [SUM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [ACC_W-1:0] quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0]  quo_q, quo_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dsr_q, dsr_d;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[ACC_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ACC_W-2:0], ge};
      rem_d = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(ACC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/wcma_front.sv
module wcma_front import wcma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_take_i
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              in_range;
  logic              enq;
  logic              deq;
  cmd_t              cmd_new;

  // Classify the incoming item
  always_comb begin
    in_range = (int'(in_item_i.cluster_index) < NUM_CLUSTERS) &&
               (int'(in_item_i.variable_index) < NUM_VARIABLES);
    cmd_new.addr = ADDR_W'(int'(in_item_i.cluster_index) * NUM_VARIABLES +
                           int'(in_item_i.variable_index));
    cmd_new.weight       = in_item_i.weight;
    cmd_new.sample_value = in_item_i.sample_value;
    cmd_new.weight_sum   = in_item_i.weight_sum;
    priority if (!in_range) begin
      cmd_new.kind = CMD_NULL;
    end else if (in_item_i.req_type == REQ_ACC) begin
      cmd_new.kind = CMD_ACC;
    end else if (in_item_i.weight_sum == '0) begin
      cmd_new.kind = CMD_ZERO;
    end else begin
      cmd_new.kind = CMD_RD;
    end
  end

  assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
  // Drop out-of-range accumulates here, they have no effect
  assign enq  = push && !full && !(in_item_i.req_type == REQ_ACC && !in_range);
  assign deq  = cmd_take_i && (count_q != '0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (enq && !deq) begin
      count_d = count_q + QCNT_W'(1);
    end else if (deq && !enq) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

endmodule

### rtl/wcma_back.sv
module wcma_back import wcma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_take_o,
  output logic      res_valid_o,
  output out_item_t res_o,
  input  logic      res_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]               state_q, state_d;
  cmd_t                     cmd_q, cmd_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     neg_q, neg_d;
  out_item_t                res_q, res_d;
  logic [ENTRY_COUNT-1:0]   vld_q, vld_d;

  logic [ACC_W-1:0]  mem [ENTRY_COUNT];
  logic [ACC_W-1:0]  rd_data_q;
  logic              mem_we;
  logic [ACC_W-1:0]  mem_wdata;
  logic [ACC_W-1:0]  acc;

  logic              div_start;
  logic [ACC_W-1:0]  div_dividend;
  logic              div_done;
  logic [ACC_W-1:0]  quotient;

  wcma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cmd_q.weight_sum),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i;

  // Entries never written since reset or readout read as zero
  assign acc = vld_q[cmd_q.addr] ? rd_data_q : '0;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    res_d        = res_q;
    vld_d        = vld_q;
    mem_we       = 1'b0;
    mem_wdata    = acc + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    div_start    = 1'b0;
    div_dividend = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          prod_d = PROD_W'($signed({1'b0, cmd_i.weight})) * PROD_W'(cmd_i.sample_value);
          if (cmd_i.kind == CMD_NULL) begin
            res_d   = '0;
            state_d = ST_RES;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        unique case (cmd_q.kind)
          CMD_ACC: begin
            mem_we              = 1'b1;
            vld_d[cmd_q.addr]   = 1'b1;
            state_d             = ST_IDLE;
          end
          CMD_RD: begin
            vld_d[cmd_q.addr] = 1'b0;
            neg_d             = acc[ACC_W-1];
            div_start         = 1'b1;
            state_d           = ST_DIV;
          end
          CMD_ZERO: begin
            vld_d[cmd_q.addr] = 1'b0;
            res_d             = '0;
            state_d           = ST_RES;
          end
          CMD_NULL: begin
            res_d   = '0;
            state_d = ST_RES;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        // Restore the sign and clip to the value range
        if (div_done) begin
          res_d.saturated = 1'b0;
          if (neg_q) begin
            if (quotient > ACC_W'(MEAN_MIN)) begin
              res_d.mean_value = MEAN_MIN;
              res_d.saturated  = 1'b1;
            end else begin
              res_d.mean_value = ~quotient[VAL_W-1:0] + VAL_W'(1);
            end
          end else begin
            if (quotient > ACC_W'(MEAN_MAX)) begin
              res_d.mean_value = MEAN_MAX;
              res_d.saturated  = 1'b1;
            end else begin
              res_d.mean_value = quotient[VAL_W-1:0];
            end
          end
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  // Accumulator memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_q.addr] <= mem_wdata;
    end
    rd_data_q <= mem[cmd_i.addr];
  end

  assign res_valid_o = (state_q == ST_RES);
  assign res_o       = res_q;

endmodule

### rtl/weighted_cluster_mean_accumulator.sv
// An accumulate passes the queue, then the back end reads, adds and writes its entry.
// A readout passes the queue and reads its entry, then runs the divider; with a zero weight
// sum it skips the divider and gives a mean of zero.
// The back end takes no new command until it is through with the last one; an accumulate
// waits on the read-modify-write of the memory, a readout on the 64-step bit-serial divider.
// Reset clears control state and the entry valid bits at once; all accumulators read as zero.
module weighted_cluster_mean_accumulator import wcma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_take;
  logic      res_valid;
  out_item_t res;
  logic      res_ready;
  logic      out_vld_q;
  out_item_t out_q;

  wcma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  wcma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: load a new item when empty or when the held one leaves
  assign res_ready = !out_vld_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.saturated) |->
      ($unsigned(out_item_o.mean_value) == MEAN_MAX ||
       $unsigned(out_item_o.mean_value) == MEAN_MIN))
    else $error("saturated mean not at a range limit");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("back result changed while stalled");

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> !empty)
    else $error("handed-over result missing from output register");
`endif

endmodule

### tb/sv/tb_weighted_cluster_mean_accumulator.sv
module tb_weighted_cluster_mean_accumulator;
  import wcma_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int TAIL_ITEMS   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  // Predict the weighted means and hold them until the block returns them
  class mean_scoreboard;
    bit [ACC_W-1:0] product_sums [ENTRY_COUNT];
    out_item_t      means_due [$];
    int             mismatches;
    int             n_accum;
    int             n_readout;
    int             n_clipped;
    int             n_zero_sum;
    int             n_checked;

    function int pending();
      return means_due.size();
    endfunction

    // Update the accumulators for one accepted item; queue a mean on readout
    function void note_input(in_item_t it);
      int unsigned    idx;
      bit             in_range;
      bit [ACC_W-1:0] w64;
      bit [ACC_W-1:0] v64;
      bit [ACC_W-1:0] acc;
      bit [ACC_W-1:0] mag;
      bit [ACC_W-1:0] quo;
      bit [ACC_W-1:0] neg_quo;
      out_item_t      m;
      in_range = (it.cluster_index < NUM_CLUSTERS) && (it.variable_index < NUM_VARIABLES);
      idx = it.cluster_index * NUM_VARIABLES + it.variable_index;
      if (it.req_type == REQ_ACC) begin
        n_accum++;
        if (in_range) begin
          w64 = {48'd0, it.weight};
          v64 = {{32{it.sample_value[VAL_W-1]}}, it.sample_value};
          product_sums[idx] = product_sums[idx] + w64 * v64;
        end
        return;
      end
      n_readout++;
      m = '0;
      if (in_range) begin
        acc = product_sums[idx];
        product_sums[idx] = '0;
        if (it.weight_sum == '0) begin
          n_zero_sum++;
        end else begin
          mag = acc[ACC_W-1] ? -acc : acc;
          quo = mag / {32'd0, it.weight_sum};
          if (acc[ACC_W-1]) begin
            if (quo > 64'h8000_0000) begin
              m.mean_value = MEAN_MIN;
              m.saturated  = 1'b1;
            end else begin
              neg_quo = -quo;
              m.mean_value = neg_quo[VAL_W-1:0];
            end
          end else begin
            if (quo > 64'h7FFF_FFFF) begin
              m.mean_value = MEAN_MAX;
              m.saturated  = 1'b1;
            end else begin
              m.mean_value = quo[VAL_W-1:0];
            end
          end
          if (m.saturated) n_clipped++;
        end
      end
      means_due.push_back(m);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Compare one returned mean with the oldest prediction
    task check_mean(out_item_t got);
      out_item_t want;
      if (means_due.size() == 0) begin
        report_mismatch("mean with none pending", got.mean_value, '0);
        return;
      end
      want = means_due.pop_front();
      n_checked++;
      if (got.mean_value !== want.mean_value)
        report_mismatch("mean_value", got.mean_value, want.mean_value);
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", {31'd0, got.saturated}, {31'd0, want.saturated});
    endtask
  endclass

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  mean_scoreboard sb;
  int             items_sent = 0;
  bit             quiet_tail = 1'b0;
  int             push_idle_pct = 20;
  int             stall_cycles = 0;

  weighted_cluster_mean_accumulator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always #5 clk_i = ~clk_i;

  // Watch both handshakes: predict on push, check on pop
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_input(in_item);
    if (rst_ni && pop && !empty) sb.check_mean(out_item);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb_weighted_cluster_mean_accumulator failed");
      $finish;
    end
  end

  // Stall the result side in random bursts
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  function automatic in_item_t make_acc(logic [2:0] cl, logic [2:0] vr,
                                        logic [WGT_W-1:0] w, logic [VAL_W-1:0] val);
    in_item_t it;
    it                = '0;
    it.req_type       = REQ_ACC;
    it.cluster_index  = cl;
    it.variable_index = vr;
    it.weight         = w;
    it.sample_value   = val;
    it.weight_sum     = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_read(logic [2:0] cl, logic [2:0] vr, logic [SUM_W-1:0] ws);
    in_item_t it;
    it                = '0;
    it.req_type       = REQ_READ;
    it.cluster_index  = cl;
    it.variable_index = vr;
    it.weight         = WGT_W'($urandom);
    it.sample_value   = $urandom;
    it.weight_sum     = ws;
    return it;
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd32768;
      2, 3:    return WGT_W'($urandom_range(32769, 65535));
      default: return WGT_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] pick_sum();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return $urandom_range(1, 255);
      2:       return 32'h8000_0000 | $urandom;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(1, 1 << 17);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold it until accepted; then maybe idle
  task automatic send(in_item_t it);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    quiet_tail = (items_sent >= ITEM_TARGET - TAIL_ITEMS);
    if (!quiet_tail && $urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Extremes, clipping both ways, exact range limits, truncation, zero sum
  task automatic run_directed();
    send(make_acc(3'd0, 3'd0, 16'd32768, 32'h7FFF_FFFF));
    send(make_acc(3'd0, 3'd0, 16'hFFFF, 32'h7FFF_FFFF));
    send(make_read(3'd0, 3'd0, 32'd1));
    send(make_acc(3'd1, 3'd7, 16'hFFFF, 32'h8000_0000));
    send(make_read(3'd1, 3'd7, 32'd1));
    send(make_acc(3'd2, 3'd3, 16'd32768, 32'hFFFF_FFFD));
    send(make_read(3'd2, 3'd3, 32'd7));
    send(make_acc(3'd3, 3'd0, 16'd32768, 32'h8000_0000));
    send(make_read(3'd3, 3'd0, 32'd32768));
    send(make_acc(3'd3, 3'd1, 16'd32768, 32'h7FFF_FFFF));
    send(make_read(3'd3, 3'd1, 32'd32768));
    send(make_acc(3'd7, 3'd7, 16'd12345, 32'd1000));
    send(make_read(3'd7, 3'd7, 32'd0));
    send(make_read(3'd7, 3'd7, 32'd5));
    send(make_read(3'd4, 3'd4, 32'hFFFF_FFFF));
    send(make_acc(3'd5, 3'd5, 16'd32768, 32'h0001_0000));
    send(make_read(3'd5, 3'd5, 32'h8000_0000));
    send(make_acc(3'd6, 3'd2, 16'd0, 32'h1234_5678));
    send(make_read(3'd6, 3'd2, 32'd32768));
    send(make_acc(3'd6, 3'd5, 16'd1, 32'hFFFF_FFFF));
    send(make_acc(3'd6, 3'd5, 16'd1, 32'hFFFF_FFFF));
    send(make_read(3'd6, 3'd5, 32'd3));
  endtask

  // One EM mean update for a cluster: observations over all variables, then readouts
  task automatic run_fit_round();
    logic [2:0]       cl;
    logic [WGT_W-1:0] w;
    logic [SUM_W-1:0] wsum;
    int               n_obs;
    cl    = 3'($urandom_range(0, NUM_CLUSTERS - 1));
    n_obs = $urandom_range(1, 6);
    wsum  = '0;
    for (int o = 0; o < n_obs; o++) begin
      w    = pick_weight();
      wsum = wsum + SUM_W'(w);
      for (int v = 0; v < NUM_VARIABLES; v++) send(make_acc(cl, 3'(v), w, pick_value()));
    end
    for (int v = 0; v < NUM_VARIABLES; v++)
      send(make_read(cl, 3'(v), ($urandom_range(0, 9) == 0) ? pick_sum() : wsum));
  endtask

  // Scattered items with no structure
  task automatic run_noise(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = $urandom_range(0, 3) == 0 ?
           make_read(3'($urandom), 3'($urandom), pick_sum()) :
           make_acc(3'($urandom), 3'($urandom), WGT_W'($urandom), $urandom);
      send(it);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    while (items_sent < ITEM_TARGET) begin
      push_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if ($urandom_range(0, 9) < 7) run_fit_round();
      else run_noise($urandom_range(5, 30));
    end
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d accumulates and %0d readouts (%0d clipped, %0d with zero weight sum)",
             sb.n_accum, sb.n_readout, sb.n_clipped, sb.n_zero_sum);
    $display("checked %0d means, %0d mismatches", sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_weighted_cluster_mean_accumulator passed");
    end else begin
      $display("tb_weighted_cluster_mean_accumulator failed");
    end
    $finish;
  end

endmodule
